// ===== rtl/iilp_pkg.sv =====
// shared constants and types for the impulse length and padding core
package iilp_pkg;

	localparam int MaxSamples = 4096;
	localparam int IdxW       = 12;
	localparam int LenW       = 13;
	localparam int CoefW      = 32;
	localparam int AccW       = 64;

	localparam logic [LenW-1:0]  MaxPadReset = 13'd4096;
	localparam logic [31:0]      TolReset    = 32'd4295;
	localparam logic [CoefW-1:0] CoefOne     = 32'h1000_0000;

	localparam logic [0:0] RegMaxPad = 1'b0;
	localparam logic [0:0] RegTol    = 1'b1;

	// divider request and response between sequencer and divide unit
	typedef struct packed {
		logic            start;
		logic [AccW-1:0] dividend;
		logic [CoefW-1:0] divisor;
	} iilp_div_req_t;

	typedef struct packed {
		logic             done;
		logic [CoefW-1:0] quotient;
	} iilp_div_rsp_t;

	function automatic logic [AccW:0] sat_add64(input logic [AccW-1:0] a, input logic [AccW-1:0] b);
		logic [AccW:0] s;
		s = {1'b0, a} + {1'b0, b};
		sat_add64 = s[AccW] ? {1'b0, {AccW{1'b1}}} : s;
	endfunction

endpackage

// ===== rtl/iir_impulse_length_padding_core.sv =====
// top level: sequencer for impulse simulation, energy store and tail scan
// samples per filter: max_padding clamped to 1..4096; a zero a0 goes straight to the result
// per sample: nine products through the shared multiplier, a bit-serial divide, then a square
// and store; then a threshold from two product halves and a backward scan of stored entries
// throughput: one filter at a time, s_tready high only in idle; a result waits in m_tdata
// reset: asynchronous active low; registers go to defaults, running maximum to one
module iir_impulse_length_padding_core
	import iilp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// num_c0..num_c4, den_c0..den_c4
	input  logic [319:0] s_tdata,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// impulse_length, padding, degenerate, zero fill
	output logic [31:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam logic [3:0] StIdle = 4'd0, StMul = 4'd1, StMulW = 4'd2, StAcc = 4'd3,
		StDiv = 4'd4, StDivW = 4'd5, StSq = 4'd6, StSqW = 4'd7, StThr = 4'd8,
		StThrW = 4'd9, StScan = 4'd10, StScanW = 4'd11, StOut = 4'd12;

	logic [3:0]       state_q;
	logic [LenW-1:0]  maxpad_q;
	logic [31:0]      tol_q;
	logic [LenW-1:0]  runmax_q;
	logic [CoefW-1:0] b_q [5];
	logic [CoefW-1:0] a_q [5];
	logic [CoefW-1:0] xh_q [4];
	logic [CoefW-1:0] yh_q [4];
	logic             last_q;
	logic [LenW-1:0]  nsamp_q;
	logic [LenW-1:0]  n_q;
	logic [3:0]       term_q;
	logic [AccW-1:0]  acc_q;
	logic [AccW-1:0]  tot_q;
	logic [AccW-1:0]  tail_q;
	logic [AccW-1:0]  thr_q;
	logic [CoefW-1:0] y_q;
	logic [LenW-1:0]  len_q;
	logic             degen_q;
	logic             mvalid_q;
	logic [31:0]      mdata_q;
	logic [AccW-1:0]  store [MaxSamples];
	logic [AccW-1:0]  rd_q;

	logic [CoefW-1:0] op_a, op_b, xcur;
	logic             mul_sgn;
	logic             out_free;
	logic [AccW-1:0]  prod_s1, q16, prod_mag;
	iilp_div_req_t    dreq;
	iilp_div_rsp_t    drsp;
	logic [AccW:0]    tail_add, tot_add;
	logic [LenW-1:0]  newmax;
	logic [LenW:0]    pad2;
	logic [LenW-1:0]  nsamp_in;

	iilp_mac u_mac (.clk(clk), .op_sgn(mul_sgn), .op_a(op_a), .op_b(op_b), .prod_s1(prod_s1));
	iilp_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr[2])
			RegMaxPad: prdata = {19'd0, maxpad_q};
			RegTol:    prdata = tol_q;
			default:   prdata = '0;
		endcase
	end

	assign s_tready = (state_q == StIdle);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	// output register free or being emptied this cycle
	assign out_free = !mvalid_q || m_tready;

	always_comb begin
		if (maxpad_q == '0)              nsamp_in = 13'd1;
		else if (maxpad_q > 13'(MaxSamples)) nsamp_in = 13'(MaxSamples);
		else                             nsamp_in = maxpad_q;
	end

	// operand select: term 0 b0*x, terms 1..4 b*xh, 5..8 a*yh; square and threshold halves by state
	always_comb begin
		xcur = (n_q == '0) ? CoefOne : '0;
		op_a = b_q[0];
		op_b = xcur;
		// threshold halves are unsigned products
		mul_sgn = (state_q != StThr);
		if (state_q == StSq) begin
			op_a = y_q; op_b = y_q;
		end else if (state_q == StThr) begin
			op_a = term_q[0] ? tot_q[63:32] : tot_q[31:0];
			op_b = tol_q;
		end else if (term_q >= 4'd1 && term_q <= 4'd4) begin
			op_a = b_q[3'(term_q)];
			op_b = xh_q[2'(term_q - 4'd1)];
		end else if (term_q >= 4'd5 && term_q <= 4'd8) begin
			op_a = a_q[3'(term_q - 4'd4)];
			op_b = yh_q[2'(term_q - 4'd5)];
		end
		// truncate toward zero when dividing by 16
		prod_mag = prod_s1[63] ? (~prod_s1 + 1'b1) : prod_s1;
		q16      = prod_s1[63] ? (~{4'b0, prod_mag[63:4]} + 1'b1) : {4'b0, prod_s1[63:4]};
		dreq.start    = (state_q == StDiv);
		dreq.dividend = acc_q;
		dreq.divisor  = a_q[0];
		tail_add = sat_add64(tail_q, rd_q);
		tot_add  = sat_add64(tot_q, prod_s1);
		newmax   = (len_q > runmax_q) ? len_q : runmax_q;
		pad2     = {newmax, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			maxpad_q <= MaxPadReset;
			tol_q    <= TolReset;
			runmax_q <= 13'd1;
			mvalid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == RegMaxPad)
				maxpad_q <= pwdata[LenW-1:0];
			if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == RegTol)
				tol_q <= pwdata;
			if (state_q == StOut && out_free)
				mvalid_q <= 1'b1;
			else if (mvalid_q && m_tready)
				mvalid_q <= 1'b0;
			unique case (state_q)
				StIdle:  if (s_tvalid && s_tready)
					state_q <= (s_tdata[191:160] == '0) ? StOut : StMul;
				StMul:   state_q <= StMulW;
				StMulW:  state_q <= StAcc;
				StAcc:   state_q <= (term_q == 4'd8) ? StDiv : StMul;
				StDiv:   state_q <= StDivW;
				StDivW:  if (drsp.done) state_q <= StSq;
				StSq:    state_q <= StSqW;
				StSqW:   state_q <= (n_q == nsamp_q - 1'b1) ? StThr : StMul;
				StThr:   state_q <= StThrW;
				StThrW:  state_q <= term_q[0] ? StScan : StThr;
				StScan:  state_q <= StScanW;
				StScanW: if (tail_add[AccW-1:0] > thr_q || n_q == '0) state_q <= StOut;
					else state_q <= StScan;
				StOut: if (out_free) begin
					state_q  <= StIdle;
					runmax_q <= last_q ? 13'd1 : newmax;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			StIdle: begin
				for (int j = 0; j < 5; j++) begin
					b_q[j] <= s_tdata[32*j +: 32];
					a_q[j] <= s_tdata[160 + 32*j +: 32];
				end
				for (int j = 0; j < 4; j++) begin
					xh_q[j] <= '0;
					yh_q[j] <= '0;
				end
				last_q  <= s_tlast;
				nsamp_q <= nsamp_in;
				len_q   <= nsamp_in;
				degen_q <= (s_tdata[191:160] == '0);
				n_q     <= '0;
				term_q  <= '0;
				acc_q   <= '0;
				tot_q   <= '0;
			end
			StAcc: begin
				acc_q  <= (term_q >= 4'd5) ? acc_q - q16 : acc_q + q16;
				term_q <= term_q + 1'b1;
			end
			StDivW: if (drsp.done) y_q <= drsp.quotient;
			StSqW: begin
				store[n_q[IdxW-1:0]] <= prod_s1;
				tot_q  <= tot_add[AccW-1:0];
				xh_q[0] <= xcur;
				yh_q[0] <= y_q;
				for (int j = 1; j < 4; j++) begin
					xh_q[j] <= xh_q[j-1];
					yh_q[j] <= yh_q[j-1];
				end
				acc_q  <= '0;
				term_q <= '0;
				if (n_q != nsamp_q - 1'b1) n_q <= n_q + 1'b1;
				else thr_q <= '0;
			end
			StThrW: begin
				if (term_q[0]) thr_q <= thr_q + prod_s1;
				else thr_q <= {32'd0, prod_s1[63:32]};
				term_q <= term_q + 1'b1;
				tail_q <= '0;
				len_q  <= 13'd1;
			end
			StScan: rd_q <= store[n_q[IdxW-1:0]];
			StScanW: begin
				tail_q <= tail_add[AccW-1:0];
				if (tot_q != '0 && tail_add[AccW-1:0] > thr_q) len_q <= n_q + 1'b1;
				else if (n_q != '0) n_q <= n_q - 1'b1;
			end
			StOut: if (out_free) begin
				if (pad2 > {1'b0, nsamp_q}) mdata_q <= {5'd0, degen_q, nsamp_q, len_q};
				else mdata_q <= {5'd0, degen_q, pad2[LenW-1:0], len_q};
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) s_tready |-> state_q == StIdle)
		else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == StOut |=> mvalid_q)
		else $error("result not presented");
	assert property (@(posedge clk) disable iff (!arst_n) mvalid_q |-> runmax_q != '0)
		else $error("running maximum zero");

endmodule

// ===== rtl/iilp_div.sv =====
// radix-2 restoring divider producing the saturated q4.28 sample
module iilp_div
	import iilp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  iilp_div_req_t req,
	output iilp_div_rsp_t rsp
);

	// magnitude quotient needs 64+4 bits: shift dividend left 4 then divide
	localparam int NumW = AccW + 4;

	logic [NumW-1:0]  num_q;
	logic [CoefW:0]   rem_q;
	logic [NumW-1:0]  quo_q;
	logic [CoefW-1:0] den_q;
	logic             neg_q;
	logic [6:0]       cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [CoefW:0]   rem_sh;
	logic [CoefW+1:0] rem_sub;
	logic [AccW-1:0]  mag_a;
	logic [CoefW-1:0] mag_d;

	always_comb begin
		mag_a   = req.dividend[AccW-1] ? (~req.dividend + 1'b1) : req.dividend;
		mag_d   = req.divisor[CoefW-1] ? (~req.divisor + 1'b1) : req.divisor;
		rem_sh  = {rem_q[CoefW-1:0], num_q[NumW-1]};
		rem_sub = {1'b0, rem_sh} - {2'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= {mag_a, 4'b0};
			den_q <= mag_d;
			neg_q <= req.dividend[AccW-1] ^ req.divisor[CoefW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NumW-2:0], 1'b0};
			if (!rem_sub[CoefW+1]) begin
				rem_q <= rem_sub[CoefW:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	logic big;
	always_comb begin
		big = |quo_q[NumW-1:31];
		rsp.done = done_q;
		if (neg_q) begin
			if (big || quo_q[30:0] == 31'd0)
				rsp.quotient = big ? 32'h8000_0000 : 32'd0;
			else
				rsp.quotient = ~{1'b0, quo_q[30:0]} + 1'b1;
		end else begin
			rsp.quotient = big ? 32'h7FFF_FFFF : {1'b0, quo_q[30:0]};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q)
		else $error("divider done while busy");
	assert property (@(posedge clk) disable iff (!arst_n) req.start |=> busy_q)
		else $error("divider did not start");
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 7'd0)
		else $error("divider count underflow");

endmodule

// ===== rtl/iilp_mac.sv =====
// shared 32x32 signed or unsigned multiplier with registered product
module iilp_mac
	import iilp_pkg::*;
(
	input  logic             clk,
	input  logic             op_sgn,
	input  logic [CoefW-1:0] op_a,
	input  logic [CoefW-1:0] op_b,
	output logic [AccW-1:0]  prod_s1
);

	logic signed [CoefW:0]     ext_a, ext_b;
	logic signed [2*CoefW+1:0] full;

	// one extra top bit selects signed or unsigned operands
	always_comb begin
		ext_a = {op_sgn & op_a[CoefW-1], op_a};
		ext_b = {op_sgn & op_b[CoefW-1], op_b};
		full  = ext_a * ext_b;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= full[AccW-1:0];
	end

endmodule

// ===== test/tb_iir_impulse_length_padding_core.sv =====
// testbench for the iir impulse length and padding core: directed table then random filters
`timescale 1ns / 100ps

module tb_iir_impulse_length_padding_core;
	import iilp_pkg::*;

	localparam logic [31:0] Q_ONE     = 32'h1000_0000;
	localparam logic [2:0]  ADDR_MPAD = 3'd0;
	localparam logic [2:0]  ADDR_TOL  = 3'd4;
	localparam int          CYCLE_CAP = 6_000_000;

	typedef struct packed {
		logic [12:0] len;
		logic [12:0] pad;
		logic        deg;
	} filt_res_t;

	typedef struct {
		bit          set_cfg;
		logic [12:0] mpad;
		logic [31:0] tol;
		logic        last;
		logic [319:0] coef;
		bit          typed;
		filt_res_t   res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// num_c0..num_c4, den_c0..den_c4
	logic [319:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// impulse_length, padding, degenerate, zero fill
	logic [31:0] m_tdata;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	iir_impulse_length_padding_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model state
	logic [12:0] cfg_mpad = MaxPadReset;
	logic [31:0] cfg_tol = TolReset;
	int          peak_len = 1;
	bit [63:0]   energy_mem [MaxSamples];

	filt_res_t pending_q [$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  calm = 0;
	bit  hold_req = 0;
	int  stall_left = 0;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [31:0] e, input logic [31:0] a);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %0d got %0d at cycle %0d", what, e, a, cycles);
	endtask

	function automatic bit [63:0] sat_sum(input bit [63:0] x, input bit [63:0] y);
		bit [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
	endfunction

	function automatic filt_res_t predict_padding(input logic last, input logic [319:0] c);
		longint b [5], a [5], xh [4], yh [4];
		longint acc, y, xcur;
		bit [63:0] tot, thr, tail, ma, md, qi, r, mag;
		int n, j, samples, len, pad;
		bit neg, found;
		filt_res_t res;
		samples = (cfg_mpad == 0) ? 1 : (cfg_mpad > MaxSamples) ? MaxSamples : int'(cfg_mpad);
		for (j = 0; j < 5; j++) begin
			b[j] = longint'($signed(c[32*j +: 32]));
			a[j] = longint'($signed(c[160 + 32*j +: 32]));
		end
		if (a[0] == 0) begin
			len = samples;
		end else begin
			for (j = 0; j < 4; j++) begin
				xh[j] = 0;
				yh[j] = 0;
			end
			tot = 0;
			for (n = 0; n < samples; n++) begin
				xcur = (n == 0) ? longint'(Q_ONE) : 64'sd0;
				acc = (b[0] * xcur) / 16;
				for (j = 1; j < 5; j++) begin
					acc += (b[j] * xh[j-1]) / 16;
					acc -= (a[j] * yh[j-1]) / 16;
				end
				ma = (acc < 0) ? -acc : acc;
				md = (a[0] < 0) ? -a[0] : a[0];
				qi = ma / md;
				r = ma % md;
				neg = (acc < 0) != (a[0] < 0);
				if (qi >= (64'd1 << 28))
					mag = 64'd1 << 32;
				else
					mag = qi * 16 + (r * 16) / md;
				if (neg) begin
					if (mag > 64'h8000_0000)
						mag = 64'h8000_0000;
					y = -longint'(mag);
				end else begin
					if (mag > 64'h7FFF_FFFF)
						mag = 64'h7FFF_FFFF;
					y = longint'(mag);
				end
				energy_mem[n] = y * y;
				tot = sat_sum(tot, energy_mem[n]);
				for (j = 3; j > 0; j--) begin
					xh[j] = xh[j-1];
					yh[j] = yh[j-1];
				end
				xh[0] = xcur;
				yh[0] = y;
			end
			len = 1;
			if (tot != 0) begin
				thr = (tot >> 32) * cfg_tol + (((tot & 64'hFFFF_FFFF) * cfg_tol) >> 32);
				tail = 0;
				found = 0;
				for (n = samples - 1; n >= 0 && !found; n--) begin
					tail = sat_sum(tail, energy_mem[n]);
					if (tail > thr) begin
						len = n + 1;
						found = 1;
					end
				end
			end
		end
		if (len > peak_len)
			peak_len = len;
		pad = 2 * peak_len;
		if (pad > samples)
			pad = samples;
		res.len = len[12:0];
		res.pad = pad[12:0];
		res.deg = (a[0] == 0);
		if (last)
			peak_len = 1;
		return res;
	endfunction

	// result side: stall bursts, one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 0;
			stall_left = 20000;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 18);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		filt_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				flag_mismatch("unexpected result", 0, m_tdata);
			end else begin
				e = pending_q.pop_front();
				if (m_tdata[12:0] !== e.len)
					flag_mismatch("impulse_length", e.len, m_tdata[12:0]);
				if (m_tdata[25:13] !== e.pad)
					flag_mismatch("padding", e.pad, m_tdata[25:13]);
				if (m_tdata[26] !== e.deg)
					flag_mismatch("degenerate", e.deg, m_tdata[26]);
			end
		end
	end

	task automatic send_filter(input logic last, input logic [319:0] c, input bit typed,
			input filt_res_t typed_res);
		filt_res_t p;
		if (!calm && $urandom_range(0, 3) == 0) begin
			@(negedge clk) s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		p = predict_padding(last, c);
		pending_q.push_back(typed ? typed_res : p);
	endtask

	task automatic drain_results();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] val, input logic [31:0] mask);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= val;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & mask) !== (val & mask))
			flag_mismatch("register readback", val & mask, prdata);
		@(negedge clk) begin
			psel <= 1'b0;
			penable <= 1'b0;
		end
	endtask

	task automatic set_config(input logic [12:0] mpad, input logic [31:0] tol);
		drain_results();
		apb_write(ADDR_MPAD, {19'd0, mpad}, 32'h1FFF);
		apb_write(ADDR_TOL, tol, 32'hFFFF_FFFF);
		cfg_mpad = mpad;
		cfg_tol = tol;
	endtask

	function automatic logic [319:0] pack_coefs(input logic [31:0] b0, b1, b2, b3, b4,
			input logic [31:0] a0, a1, a2, a3, a4);
		return {a4, a3, a2, a1, a0, b4, b3, b2, b1, b0};
	endfunction

	function automatic logic [31:0] near_zero(input int unsigned span);
		return $urandom_range(0, 2 * span) - span;
	endfunction

	function automatic logic [319:0] random_coefs();
		logic [319:0] c;
		int k;
		k = $urandom_range(0, 9);
		if (k < 6) begin
			// stable-ish filter near unit gain with random content
			c = pack_coefs(near_zero(Q_ONE), near_zero(Q_ONE), near_zero(Q_ONE / 2),
				near_zero(Q_ONE / 4), near_zero(Q_ONE / 8), Q_ONE + near_zero(Q_ONE / 4),
				near_zero(Q_ONE), near_zero(Q_ONE / 4), near_zero(Q_ONE / 8),
				near_zero(Q_ONE / 16));
		end else if (k < 9) begin
			for (int j = 0; j < 10; j++)
				c[32*j +: 32] = $urandom;
		end else begin
			for (int j = 0; j < 10; j++)
				c[32*j +: 32] = $urandom;
			c[160 +: 32] = '0;
		end
		return c;
	endfunction

	dir_row_t rows [14];
	filt_res_t none_res = '0;
	logic [319:0] ident, pole;
	int sent = 0;
	int tol_pick;
	logic [31:0] rtol;
	logic [12:0] rpad;

	initial begin
		ident = pack_coefs(Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 0, 0);
		pole  = pack_coefs(Q_ONE, 0, 0, 0, 0, Q_ONE, 32'hF800_0000, 0, 0, 0);
		rows[0]  = '{1, 13'd4096, TolReset, 0, pack_coefs(Q_ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			1, '{13'd4096, 13'd4096, 1'b1}};
		rows[1]  = '{0, 0, 0, 1, ident, 1, '{13'd1, 13'd4096, 1'b0}};
		rows[2]  = '{1, 13'd0, 32'd0, 0, pack_coefs(0, 0, 0, 0, 0, Q_ONE, 0, 0, 0, 0),
			1, '{13'd1, 13'd1, 1'b0}};
		rows[3]  = '{0, 0, 0, 1, {{5{32'h7FFF_FFFF}}, {5{32'h8000_0000}}}, 0, none_res};
		rows[4]  = '{1, 13'd8191, 32'hFFFF_FFFF, 1,
			{{4{32'hFFFF_FFFF}}, 32'd0, {5{32'hFFFF_FFFF}}}, 1, '{13'd4096, 13'd4096, 1'b1}};
		rows[5]  = '{1, 13'd16, TolReset, 0, ident, 1, '{13'd1, 13'd2, 1'b0}};
		rows[6]  = '{0, 0, 0, 0, pole, 0, none_res};
		rows[7]  = '{0, 0, 0, 0, {10{32'h7FFF_FFFF}}, 0, none_res};
		// quotient saturation from a tiny divisor
		rows[8]  = '{0, 0, 0, 0, pack_coefs(32'h7FFF_FFFF, 0, 0, 0, 0, 32'd1, 0, 0, 0, 0),
			0, none_res};
		rows[9]  = '{0, 0, 0, 1, pack_coefs(Q_ONE, Q_ONE, 0, 0, 0, -Q_ONE, 0, 0, 0, 0),
			0, none_res};
		// unstable pole, energy saturates
		rows[10] = '{0, 0, 0, 0, pack_coefs(Q_ONE, 0, 0, 0, 0, Q_ONE, 32'hE000_0000, 0, 0, 0),
			0, none_res};
		rows[11] = '{1, 13'd40, 32'd0, 0, pole, 0, none_res};
		rows[12] = '{0, 0, 0, 1, {Q_ONE, {9{32'hFFFF_FFFF}}}, 0, none_res};
		rows[13] = '{1, 13'd40, 32'hFFFF_FFFF, 1,
			pack_coefs(Q_ONE, 0, 0, 0, 0, Q_ONE, 32'hF199_999A, 0, 0, 0), 0, none_res};

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		foreach (rows[i]) begin
			if (rows[i].set_cfg)
				set_config(rows[i].mpad, rows[i].tol);
			send_filter(rows[i].last, rows[i].coef, rows[i].typed, rows[i].res);
			sent++;
		end

		while (sent < 114) begin
			tol_pick = $urandom_range(0, 5);
			case (tol_pick)
				0: rtol = 32'd0;
				1: rtol = 32'hFFFF_FFFF;
				2: rtol = TolReset;
				3: rtol = $urandom_range(1, 1 << 20);
				default: rtol = $urandom;
			endcase
			rpad = ($urandom_range(0, 9) == 0) ? 13'($urandom_range(0, 2)) :
				13'($urandom_range(3, 40));
			set_config(rpad, rtol);
			if (sent >= 94)
				calm = 1;
			if (sent < 20)
				hold_req = 1;
			repeat ($urandom_range(6, 14)) begin
				send_filter($urandom_range(0, 3) == 0, random_coefs(), 0, none_res);
				sent++;
			end
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
